@@ src/swlf_pkg.sv @@
// Shared types and constants of the one-dimensional shallow-water solver.
`default_nettype none
package swlf_pkg;

  // Sequencer states of the solver.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_WS_RD,
    ST_WS_LAT,
    ST_WS_MUL,
    ST_WS_DIV1,
    ST_WS_DIV2,
    ST_DT,
    ST_DT_DIV,
    ST_CX_START,
    ST_CX_DIV,
    ST_UP_RD,
    ST_UP_LAT,
    ST_UP_CALC,
    ST_DONE
  } state_t;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CELL_COUNT = 3'd0;
  localparam logic [2:0] CFG_CELL_WIDTH = 3'd1;
  localparam logic [2:0] CFG_START_TIME = 3'd2;
  localparam logic [2:0] CFG_END_TIME   = 3'd3;
  localparam logic [2:0] CFG_DRY_TOL    = 3'd4;

  // Saturation limits of a signed 32-bit fixed-point value.
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ src/shallow_water_lax_friedrichs_1d.sv @@
// Top level of the one-dimensional Lax-Friedrichs shallow-water solver.
//
//  Channel | Ports                                         | Moves
//  --------+-----------------------------------------------+---------------------------------
//  in      | in_valid/in_ready, operation, index, h, q     | one command word
//  out     | out_valid/out_ready, h, q, reached time       | one result word per command word
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | one register write word
//
// Cell writes and reads stream back to back; a read word shows the cell on the next
// cycle through the registered memory port. A run keeps the block busy: each time
// step makes a wave-speed pass (the shared divider used twice per wet cell), a flux
// pass (one shared multiplier), and the step-length and Courant divisions.
// Reset is synchronous and active low; it restores the register defaults and
// clears the reached time. The cell memories hold nothing defined until
// written. A stalled result word stalls only the input side.
`default_nettype none
module shallow_water_lax_friedrichs_1d #(
  parameter int MAX_CELLS = 1024,
  parameter int FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [9:0]         in_cell_index,
  input  wire logic signed [31:0] in_height_in,
  input  wire logic signed [31:0] in_discharge_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_height_out,
  output logic signed [31:0]      out_discharge_out,
  output logic [30:0]             out_reached_time,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);

  // Gravity and half gravity rounded to the fixed-point grid.
  localparam longint unsigned G_CODE  = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned HG_CODE = ((64'd981 << FRAC_BITS) + 64'd100) / 64'd200;
  localparam logic [33:0] G_QUART = 34'(G_CODE >> 2);
  localparam logic [1:0]  G_LOW   = 2'(G_CODE & 64'd3);
  localparam logic [33:0] HG      = 34'(HG_CODE);

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? swlf_pkg::Q_MIN : swlf_pkg::Q_MAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? swlf_pkg::Q_MIN : swlf_pkg::Q_MAX;
    return s[31:0];
  endfunction

  // Product shifted down with rounding toward minus infinity, then saturated.
  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_BITS;
    if (sh > 64'sd2147483647) return swlf_pkg::Q_MAX;
    if (sh < -64'sd2147483648) return swlf_pkg::Q_MIN;
    return sh[31:0];
  endfunction

  function automatic logic [30:0] clamp31(input logic [65:0] v);
    if (|v[65:31]) return 31'h7FFF_FFFF;
    return v[30:0];
  endfunction

  // Configuration registers and control state.
  logic [10:0] cell_count_r;
  logic [30:0] cell_width_r, start_time_r, end_time_r, dry_tol_r;
  swlf_pkg::state_t state_r, state_nxt;
  logic        out_valid_r, out_show_r;
  logic [30:0] cur_time_r;

  // Run bookkeeping.
  logic [CW-1:0] n_r, idx_r;
  logic [3:0]    step_r;
  logic [30:0]   t_r, dx_r, lmax_r, dt_r;
  logic signed [31:0] cxf_r, cxh_r;

  // Wave-speed pass.
  logic [30:0] hu_r, vel_r, b_r;
  logic [31:0] aq_r;
  logic [63:0] qq_r;
  logic [33:0] um_a_r;
  logic [31:0] um_b_r;
  logic [65:0] up_r;

  // Flux pass: current cell b, previous cell a, pending sums of cell a.
  logic signed [31:0] hb_r, qb_r, wsb_r, fb_r, ha_r, qa_r, wsa_r, fa_r;
  logic signed [31:0] pend_h_r, pend_q_r, flh_r;
  logic signed [31:0] sm_a_r, sm_b_r;
  logic signed [63:0] sp_r;

  // Shared restoring divider and square-root unit.
  logic [63:0] div_q_r;
  logic [32:0] div_rem_r, div_den_r;
  logic [6:0]  div_cnt_r;
  logic        div_busy_r;
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r;
  logic        sq_busy_r;

  // Cell store {h, q} and scratch store {wave speed, momentum flux}.
  logic [63:0] cell_mem [MAX_CELLS];
  logic [63:0] scr_mem  [MAX_CELLS];
  logic [63:0] cell_rd_r, scr_rd_r;

  // Control drawn from the state.
  logic          cell_we, cell_re, scr_we, scr_re, div_start, sq_start;
  logic [AW-1:0] cell_wa, cell_ra, scr_a;
  logic [63:0]   cell_wd, scr_wd, div_dividend, sq_x;
  logic [32:0]   div_den;

  logic          in_fire, idx_ok, is_last, wet;
  logic [AW-1:0] in_addr, idx_addr, prev_addr;
  logic [CW-1:0] n_c, idx_inc;
  logic signed [31:0] h_c, q_c, mq, lmx;
  logic [31:0]   aq_c;
  logic [63:0]   quarter;
  logic [30:0]   ws_c, f_c, rem_c, dt_c, cx_c;
  logic [33:0]   rem_sh;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == swlf_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign in_addr   = AW'(in_cell_index);
  assign idx_ok    = 32'(in_cell_index) < 32'(MAX_CELLS);

  assign out_valid         = out_valid_r;
  assign out_height_out    = out_show_r ? $signed(cell_rd_r[63:32]) : 32'sd0;
  assign out_discharge_out = out_show_r ? $signed(cell_rd_r[31:0]) : 32'sd0;
  assign out_reached_time  = cur_time_r;

  assign idx_inc   = CW'(idx_r + CW'(1));
  assign is_last   = (idx_inc == n_r);
  assign idx_addr  = idx_r[AW-1:0];
  assign prev_addr = AW'(idx_r - CW'(1));

  // Cell count limited to the memory depth and to at least two cells.
  always_comb begin
    if (cell_count_r < 11'd2) n_c = CW'(2);
    else if (32'(cell_count_r) > 32'(MAX_CELLS)) n_c = CW'(MAX_CELLS);
    else n_c = CW'(cell_count_r);
  end

  // A cell is wet when its height is positive and not below the tolerance.
  assign h_c  = $signed(cell_rd_r[63:32]);
  assign q_c  = $signed(cell_rd_r[31:0]);
  assign wet  = !h_c[31] && (h_c != 32'sd0) && (h_c[30:0] >= dry_tol_r);
  assign aq_c = q_c[31] ? (~q_c + 32'd1) : q_c;

  assign quarter = up_r[63:0] + ((64'(G_LOW) * 64'(hu_r)) >> 2);
  assign ws_c = clamp31(66'(vel_r) + 66'(clamp31(66'({sq_res_r, 1'b0}))));
  assign f_c  = clamp31(66'(clamp31(66'(div_q_r))) + 66'(b_r));

  assign rem_c = end_time_r - t_r;
  always_comb begin
    if (div_q_r == 64'd0) dt_c = 31'd1;
    else if (div_q_r > 64'(rem_c)) dt_c = rem_c;
    else dt_c = div_q_r[30:0];
  end
  assign cx_c = clamp31(66'(div_q_r));

  assign mq  = qmul_sat(sp_r);
  assign lmx = (wsa_r > wsb_r) ? wsa_r : wsb_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swlf_pkg::ST_IDLE:
        if (in_fire && in_operation == swlf_pkg::OP_RUN) state_nxt = swlf_pkg::ST_STEP;
      swlf_pkg::ST_STEP:
        state_nxt = (t_r < end_time_r) ? swlf_pkg::ST_WS_RD : swlf_pkg::ST_DONE;
      swlf_pkg::ST_WS_RD: state_nxt = swlf_pkg::ST_WS_LAT;
      swlf_pkg::ST_WS_LAT: begin
        if (wet) state_nxt = swlf_pkg::ST_WS_MUL;
        else state_nxt = is_last ? swlf_pkg::ST_DT : swlf_pkg::ST_WS_RD;
      end
      swlf_pkg::ST_WS_MUL:
        if (step_r == 4'd7) state_nxt = swlf_pkg::ST_WS_DIV1;
      swlf_pkg::ST_WS_DIV1:
        if (!div_busy_r) state_nxt = swlf_pkg::ST_WS_DIV2;
      swlf_pkg::ST_WS_DIV2:
        if (!div_busy_r && !sq_busy_r)
          state_nxt = is_last ? swlf_pkg::ST_DT : swlf_pkg::ST_WS_RD;
      swlf_pkg::ST_DT:
        state_nxt = (lmax_r == 31'd0) ? swlf_pkg::ST_CX_START : swlf_pkg::ST_DT_DIV;
      swlf_pkg::ST_DT_DIV:
        if (!div_busy_r) state_nxt = swlf_pkg::ST_CX_START;
      swlf_pkg::ST_CX_START: state_nxt = swlf_pkg::ST_CX_DIV;
      swlf_pkg::ST_CX_DIV:
        if (!div_busy_r) state_nxt = swlf_pkg::ST_UP_RD;
      swlf_pkg::ST_UP_RD: state_nxt = swlf_pkg::ST_UP_LAT;
      swlf_pkg::ST_UP_LAT: state_nxt = swlf_pkg::ST_UP_CALC;
      swlf_pkg::ST_UP_CALC: begin
        if (idx_r == '0) begin
          if (step_r == 4'd4) state_nxt = swlf_pkg::ST_UP_RD;
        end else if (step_r == 4'd8 && !is_last) begin
          state_nxt = swlf_pkg::ST_UP_RD;
        end else if (step_r == 4'd12) begin
          state_nxt = swlf_pkg::ST_STEP;
        end
      end
      swlf_pkg::ST_DONE: state_nxt = swlf_pkg::ST_IDLE;
      default: state_nxt = swlf_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and unit starts.
  always_comb begin
    cell_we = 1'b0; cell_wa = idx_addr; cell_wd = '0;
    cell_re = 1'b0; cell_ra = idx_addr;
    scr_we  = 1'b0; scr_re = 1'b0; scr_a = idx_addr; scr_wd = '0;
    div_start = 1'b0; div_dividend = '0; div_den = '0;
    sq_start = 1'b0; sq_x = quarter;
    unique case (state_r)
      swlf_pkg::ST_IDLE: begin
        if (in_fire && idx_ok) begin
          cell_wa = in_addr;
          cell_ra = in_addr;
          cell_wd = {in_height_in, in_discharge_in};
          cell_we = (in_operation == swlf_pkg::OP_WRITE);
          cell_re = (in_operation == swlf_pkg::OP_READ);
        end
      end
      swlf_pkg::ST_WS_RD: cell_re = 1'b1;
      swlf_pkg::ST_WS_LAT: begin
        if (wet) begin
          div_start    = 1'b1;
          div_dividend = 64'(aq_c) << FRAC_BITS;
          div_den      = 33'(h_c[30:0]);
        end else begin
          scr_we = 1'b1;
        end
      end
      swlf_pkg::ST_WS_MUL: sq_start = (step_r == 4'd1);
      swlf_pkg::ST_WS_DIV1: begin
        div_start    = !div_busy_r;
        div_dividend = qq_r;
        div_den      = 33'(hu_r);
      end
      swlf_pkg::ST_WS_DIV2: begin
        scr_we = !div_busy_r && !sq_busy_r;
        scr_wd = {1'b0, ws_c, 1'b0, f_c};
      end
      swlf_pkg::ST_DT: begin
        div_start    = (lmax_r != 31'd0);
        div_dividend = 64'(dx_r) << FRAC_BITS;
        div_den      = {1'b0, lmax_r, 1'b0};
      end
      swlf_pkg::ST_CX_START: begin
        div_start    = 1'b1;
        div_dividend = 64'(dt_r) << FRAC_BITS;
        div_den      = 33'(dx_r);
      end
      swlf_pkg::ST_UP_RD: begin
        cell_re = 1'b1;
        scr_re  = 1'b1;
      end
      swlf_pkg::ST_UP_CALC: begin
        if (idx_r != '0 && step_r == 4'd8) begin
          cell_we = 1'b1;
          cell_wa = prev_addr;
          cell_wd = {sat_sub(pend_h_r, flh_r), sat_sub(pend_q_r, mq)};
        end else if (step_r == 4'd12) begin
          cell_we = 1'b1;
          cell_wd = {pend_h_r, sat_sub(pend_q_r, mq)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (cell_re) cell_rd_r <= cell_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_a] <= scr_wd;
    if (scr_re) scr_rd_r <= scr_mem[scr_a];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swlf_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      out_show_r   <= 1'b0;
      cur_time_r   <= '0;
      cell_count_r <= 11'd256;
      cell_width_r <= 31'd65536;
      start_time_r <= 31'd0;
      end_time_r   <= 31'd33554432;
      dry_tol_r    <= 31'd1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          swlf_pkg::CFG_CELL_COUNT: cell_count_r <= cfg_data[10:0];
          swlf_pkg::CFG_CELL_WIDTH: cell_width_r <= cfg_data;
          swlf_pkg::CFG_START_TIME: start_time_r <= cfg_data;
          swlf_pkg::CFG_END_TIME:   end_time_r   <= cfg_data;
          swlf_pkg::CFG_DRY_TOL:    dry_tol_r    <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        out_valid_r <= (in_operation != swlf_pkg::OP_RUN);
        out_show_r  <= (in_operation == swlf_pkg::OP_READ) && idx_ok;
      end else if (state_r == swlf_pkg::ST_DONE) begin
        out_valid_r <= 1'b1;
        out_show_r  <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == swlf_pkg::ST_STEP && !(t_r < end_time_r)) cur_time_r <= t_r;
    end
  end

  // Divider and square-root busy flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      sq_busy_r  <= 1'b0;
    end else begin
      if (div_start) div_busy_r <= 1'b1;
      else if (div_busy_r && div_cnt_r == 7'd63) div_busy_r <= 1'b0;
      if (sq_start) sq_busy_r <= 1'b1;
      else if (sq_busy_r && sq_bit_r == 64'd1) sq_busy_r <= 1'b0;
    end
  end

  // Restoring divider, one quotient bit a cycle.
  assign rem_sh = {div_rem_r, div_q_r[63]};
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q_r   <= div_dividend;
      div_rem_r <= '0;
      div_den_r <= div_den;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 7'd1;
      if (rem_sh >= {1'b0, div_den_r}) begin
        div_rem_r <= 33'(rem_sh - {1'b0, div_den_r});
        div_q_r   <= {div_q_r[62:0], 1'b1};
      end else begin
        div_rem_r <= rem_sh[32:0];
        div_q_r   <= {div_q_r[62:0], 1'b0};
      end
    end
  end

  // Floor square root, two radicand bits a cycle.
  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_x_r   <= sq_x;
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end else if (sq_busy_r) begin
      sq_bit_r <= sq_bit_r >> 2;
      if (sq_x_r >= sq_res_r + sq_bit_r) begin
        sq_x_r   <= sq_x_r - (sq_res_r + sq_bit_r);
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
    end
  end

  // Multipliers, each with a registered product.
  always_ff @(posedge clk) begin
    up_r <= um_a_r * um_b_r;
    sp_r <= sm_a_r * sm_b_r;
  end

  // Run datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      swlf_pkg::ST_IDLE: begin
        if (in_fire) begin
          t_r  <= start_time_r;
          dx_r <= (cell_width_r == 31'd0) ? 31'd1 : cell_width_r;
          n_r  <= n_c;
        end
      end
      swlf_pkg::ST_STEP: begin
        idx_r  <= '0;
        lmax_r <= '0;
      end
      swlf_pkg::ST_WS_LAT: begin
        hu_r   <= h_c[30:0];
        aq_r   <= aq_c;
        um_a_r <= G_QUART;
        um_b_r <= {1'b0, h_c[30:0]};
        step_r <= '0;
        if (!wet) idx_r <= idx_inc;
      end
      swlf_pkg::ST_WS_MUL: begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd1) begin
          um_a_r <= 34'(aq_r);
          um_b_r <= aq_r;
        end else if (step_r == 4'd3) begin
          qq_r   <= up_r[63:0];
          um_a_r <= 34'(hu_r);
          um_b_r <= {1'b0, hu_r};
        end else if (step_r == 4'd5) begin
          um_a_r <= HG;
          um_b_r <= {1'b0, clamp31(up_r >> FRAC_BITS)};
        end else if (step_r == 4'd7) begin
          b_r <= clamp31(up_r >> FRAC_BITS);
        end
      end
      swlf_pkg::ST_WS_DIV1:
        if (!div_busy_r) vel_r <= clamp31(66'(div_q_r));
      swlf_pkg::ST_WS_DIV2: begin
        if (!div_busy_r && !sq_busy_r) begin
          if (ws_c > lmax_r) lmax_r <= ws_c;
          idx_r <= idx_inc;
        end
      end
      swlf_pkg::ST_DT:
        if (lmax_r == 31'd0) dt_r <= rem_c;
      swlf_pkg::ST_DT_DIV:
        if (!div_busy_r) dt_r <= dt_c;
      swlf_pkg::ST_CX_DIV: begin
        if (!div_busy_r) begin
          cxf_r <= {1'b0, cx_c};
          cxh_r <= {2'b00, cx_c[30:1]};
          idx_r <= '0;
        end
      end
      swlf_pkg::ST_UP_LAT: begin
        hb_r   <= $signed(cell_rd_r[63:32]);
        qb_r   <= $signed(cell_rd_r[31:0]);
        wsb_r  <= $signed(scr_rd_r[63:32]);
        fb_r   <= $signed(scr_rd_r[31:0]);
        step_r <= '0;
      end
      swlf_pkg::ST_UP_CALC: begin
        step_r <= step_r + 4'd1;
        if (idx_r == '0) begin
          // Left wall: reflective discharge term on the first cell.
          if (step_r == 4'd0) begin
            sm_a_r <= wsb_r;
            sm_b_r <= qb_r;
          end else if (step_r == 4'd2) begin
            sm_a_r <= cxf_r;
            sm_b_r <= sat_sub(fb_r, mq);
          end else if (step_r == 4'd4) begin
            pend_h_r <= hb_r;
            pend_q_r <= sat_add(qb_r, mq);
            ha_r  <= hb_r;
            qa_r  <= qb_r;
            wsa_r <= wsb_r;
            fa_r  <= fb_r;
            idx_r <= idx_inc;
          end
        end else begin
          // Interface between the previous and the current cell.
          if (step_r == 4'd0) begin
            sm_a_r <= lmx;
            sm_b_r <= sat_sub(hb_r, ha_r);
          end else if (step_r == 4'd2) begin
            sm_a_r <= cxh_r;
            sm_b_r <= sat_sub(sat_add(qb_r, qa_r), mq);
          end else if (step_r == 4'd4) begin
            flh_r  <= mq;
            sm_a_r <= lmx;
            sm_b_r <= sat_sub(qb_r, qa_r);
          end else if (step_r == 4'd6) begin
            sm_a_r <= cxh_r;
            sm_b_r <= sat_sub(sat_add(fb_r, fa_r), mq);
          end else if (step_r == 4'd8) begin
            pend_h_r <= sat_add(hb_r, flh_r);
            pend_q_r <= sat_add(qb_r, mq);
            ha_r  <= hb_r;
            qa_r  <= qb_r;
            wsa_r <= wsb_r;
            fa_r  <= fb_r;
            sm_a_r <= wsb_r;
            sm_b_r <= qb_r;
            if (!is_last) idx_r <= idx_inc;
          end else if (step_r == 4'd10) begin
            // Right wall term on the last cell.
            sm_a_r <= cxf_r;
            sm_b_r <= sat_add(fb_r, mq);
          end else if (step_r == 4'd12) begin
            t_r <= t_r + dt_r;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ tb/shallow_water_lax_friedrichs_1d_checker.sv @@
`timescale 1ns / 1ps
// Watcher that mirrors the shallow-water solver and checks its result words.
module shallow_water_lax_friedrichs_1d_checker
  import swlf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [9:0]         in_cell_index,
  input  wire logic signed [31:0] in_height_in,
  input  wire logic signed [31:0] in_discharge_in,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] out_height_out,
  input  wire logic signed [31:0] out_discharge_out,
  input  wire logic [30:0]        out_reached_time,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  output int                      errors,
  output int                      pending,
  output int                      words_checked,
  output int                      runs_seen
);

  localparam int CELLS = 1024;
  localparam int FRAC  = 24;
  localparam longint unsigned GRAV      = ((64'd981 << FRAC) + 64'd50) / 64'd100;
  localparam longint unsigned HALF_GRAV = ((64'd981 << FRAC) + 64'd100) / 64'd200;
  localparam longint unsigned U31_MAX   = 64'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] height;
    logic signed [31:0] discharge;
    logic [30:0]        reached;
  } readout_t;

  readout_t readouts[$];

  logic [10:0]        cell_count;
  logic [30:0]        cell_width, start_time, end_time, dry_tol, sim_time;
  logic signed [31:0] height_cells[CELLS];
  logic signed [31:0] discharge_cells[CELLS];

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic signed [31:0] clip(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
    return clip(longint'(a) - longint'(b));
  endfunction

  // Product rounded toward minus infinity.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
    longint p;
    p = longint'(a) * longint'(b);
    if (p >= 0) return clip(p >>> FRAC);
    return clip(-((-p + ((64'sd1 <<< FRAC) - 64'sd1)) >>> FRAC));
  endfunction

  function automatic longint unsigned clampu(input longint unsigned v);
    return (v > U31_MAX) ? U31_MAX : v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit wet(input logic signed [31:0] h);
    return h > 0 && longint'(h) >= longint'(dry_tol);
  endfunction

  function automatic logic signed [31:0] wave_speed(input logic signed [31:0] h, q);
    longint unsigned hu, aq, vel, quarter, root, s;
    if (!wet(h)) return 0;
    hu = longint'(h);
    if (q < 0) aq = -longint'(q);
    else aq = longint'(q);
    vel = clampu((aq << FRAC) / hu);
    quarter = (GRAV >> 2) * hu + (((GRAV & 64'd3) * hu) >> 2);
    root = clampu(64'd2 * root_floor(quarter));
    s = clampu(vel + root);
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] momentum_flux(input logic signed [31:0] h, q);
    longint unsigned hu, qq, a, hh, b, s;
    if (!wet(h)) return 0;
    hu = longint'(h);
    qq = longint'(q) * longint'(q);
    a = clampu(qq / hu);
    hh = clampu((hu * hu) >> FRAC);
    b = clampu((HALF_GRAV * hh) >> FRAC);
    s = clampu(a + b);
    return s[31:0];
  endfunction

  // Time-steps the cells in use from start_time until end_time is reached.
  task automatic advance_solution();
    int n, i;
    longint unsigned dx, rem, dt, cx, lm;
    logic [30:0] t;
    logic signed [31:0] cxf, cxh, f_cur, f_next, lmax, l, fl;
    logic signed [31:0] oh[CELLS];
    logic signed [31:0] oq[CELLS];
    logic signed [31:0] ws[CELLS];
    n = cell_count;
    if (n < 2) n = 2;
    if (n > CELLS) n = CELLS;
    dx = (cell_width == 0) ? 64'd1 : 64'(cell_width);
    t = start_time;
    while (t < end_time) begin
      rem = 64'(end_time) - 64'(t);
      lmax = 0;
      for (i = 0; i < n; i++) begin
        oh[i] = height_cells[i];
        oq[i] = discharge_cells[i];
        ws[i] = wave_speed(oh[i], oq[i]);
        if (ws[i] > lmax) lmax = ws[i];
      end
      if (lmax == 0) begin
        dt = rem;
      end else begin
        lm = longint'(lmax);
        dt = (dx << FRAC) / (64'd2 * lm);
        if (dt == 0) dt = 1;
        if (dt > rem) dt = rem;
      end
      cx = clampu((dt << FRAC) / dx);
      cxf = cx[31:0];
      cxh = cx[32:1];
      // Reflective boundary on the left wall.
      f_cur = momentum_flux(oh[0], oq[0]);
      discharge_cells[0] = qadd(discharge_cells[0],
                                qmul(cxf, qsub(f_cur, qmul(ws[0], oq[0]))));
      for (i = 0; i + 1 < n; i++) begin
        l = (ws[i] > ws[i+1]) ? ws[i] : ws[i+1];
        f_next = momentum_flux(oh[i+1], oq[i+1]);
        fl = qmul(cxh, qsub(qadd(oq[i+1], oq[i]), qmul(l, qsub(oh[i+1], oh[i]))));
        height_cells[i] = qsub(height_cells[i], fl);
        height_cells[i+1] = qadd(height_cells[i+1], fl);
        fl = qmul(cxh, qsub(qadd(f_next, f_cur), qmul(l, qsub(oq[i+1], oq[i]))));
        discharge_cells[i] = qsub(discharge_cells[i], fl);
        discharge_cells[i+1] = qadd(discharge_cells[i+1], fl);
        f_cur = f_next;
      end
      // Reflective boundary on the right wall.
      discharge_cells[n-1] = qsub(discharge_cells[n-1],
                                  qmul(cxf, qadd(f_cur, qmul(ws[n-1], oq[n-1]))));
      t = t + dt[30:0];
    end
    sim_time = t;
  endtask

  always @(posedge clk) begin
    readout_t want, got;
    if (!rst_n) begin
      cell_count = 11'd256;
      cell_width = 31'd65536;
      start_time = 31'd0;
      end_time = 31'd33554432;
      dry_tol = 31'd1;
      sim_time = 31'd0;
      readouts.delete();
      errors = 0;
      words_checked = 0;
      runs_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (readouts.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = readouts.pop_front();
          words_checked++;
          if (out_height_out !== want.height)
            report($sformatf("height_out %h, expected %h", out_height_out, want.height));
          if (out_discharge_out !== want.discharge)
            report($sformatf("discharge_out %h, expected %h",
                             out_discharge_out, want.discharge));
          if (out_reached_time !== want.reached)
            report($sformatf("reached_time %h, expected %h",
                             out_reached_time, want.reached));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CELL_COUNT: cell_count = cfg_data[10:0];
          CFG_CELL_WIDTH: cell_width = cfg_data;
          CFG_START_TIME: start_time = cfg_data;
          CFG_END_TIME:   end_time = cfg_data;
          CFG_DRY_TOL:    dry_tol = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        got.height = 0;
        got.discharge = 0;
        case (in_operation)
          OP_WRITE: begin
            height_cells[in_cell_index] = in_height_in;
            discharge_cells[in_cell_index] = in_discharge_in;
          end
          OP_READ: begin
            got.height = height_cells[in_cell_index];
            got.discharge = discharge_cells[in_cell_index];
          end
          OP_RUN: begin
            advance_solution();
            runs_seen++;
          end
          default: ;
        endcase
        got.reached = sim_time;
        readouts.push_back(got);
      end
    end
    pending = readouts.size();
  end

endmodule

@@ tb/shallow_water_lax_friedrichs_1d_tb.sv @@
`timescale 1ns / 1ps
// Top of the shallow-water solver testbench: stimulus, idling and verdict.
module shallow_water_lax_friedrichs_1d_tb;
  import swlf_pkg::*;

  // The run is far below this; a hang in a solver pass ends here.
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int WORD_TARGET = 1850;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic [9:0]         in_cell_index;
  logic signed [31:0] in_height_in;
  logic signed [31:0] in_discharge_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_height_out;
  logic signed [31:0] out_discharge_out;
  logic [30:0]        out_reached_time;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;

  int errors, pending, words_checked, runs_seen;
  int words_sent;
  int cycles;
  bit idle_tx, idle_rx, hold_long, big_done, hold_done;
  // Cells written since reset; only these may be read back.
  bit written[1024];

  shallow_water_lax_friedrichs_1d u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_cell_index(in_cell_index), .in_height_in(in_height_in),
    .in_discharge_in(in_discharge_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_height_out(out_height_out),
    .out_discharge_out(out_discharge_out), .out_reached_time(out_reached_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  shallow_water_lax_friedrichs_1d_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_cell_index(in_cell_index), .in_height_in(in_height_in),
    .in_discharge_in(in_discharge_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_height_out(out_height_out),
    .out_discharge_out(out_discharge_out), .out_reached_time(out_reached_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .words_checked(words_checked),
    .runs_seen(runs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles, pending);
      $display("** shallow_water_lax_friedrichs_1d: FAILED **");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side. A requested long hold keeps out_ready low so that the block
  // fills up and has to stall its input side.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else if (pick_gap(idle_rx) > 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap(1'b1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one command word and holds it until the block takes it. When no gap
  // follows, valid stays high into the next word.
  task automatic send_word(input logic [1:0] op, input logic [9:0] idx,
                           input logic signed [31:0] h, input logic signed [31:0] q);
    int gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_cell_index <= idx;
    in_height_in <= h;
    in_discharge_in <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (op == OP_WRITE) written[idx] = 1'b1;
    gap = pick_gap(idle_tx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering words and waits until every expected result word is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] written_index();
    int k;
    do k = $urandom_range(0, 1023); while (!written[k]);
    return k[9:0];
  endfunction

  // Physically sensible water: depth from a quarter to two units, sometimes dry.
  function automatic logic signed [31:0] calm_height();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1 << 25, 1 << 22);
  endfunction

  function automatic logic signed [31:0] calm_flow();
    return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  task automatic read_some(input int k);
    repeat (k) send_word(OP_READ, written_index(), $urandom, $urandom);
  endtask

  // Plain cell traffic anywhere in the store, with full-range noise.
  task automatic stream_group(input int k);
    int r;
    repeat (k) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if (r < 25) send_word(OP_WRITE, $urandom, $urandom, $urandom);
        else send_word(OP_WRITE, $urandom, calm_height(), calm_flow());
      end else if (r < 92) begin
        read_some(1);
      end else begin
        send_word(2'd3, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // One configured solver run over freshly loaded cells. Time spans are kept
  // short against the expected step length so that a run takes few steps.
  task automatic solver_group(input bit noisy);
    int n_set, n_eff, r, i;
    logic [30:0] dx, t0, t1, tol, span;
    r = $urandom_range(0, 99);
    n_set = (r < 90) ? $urandom_range(2, 8) : $urandom_range(0, 1);
    n_eff = (n_set < 2) ? 2 : n_set;
    r = $urandom_range(0, 99);
    if (r < 70) dx = $urandom_range(1 << 26, 1 << 20);
    else if (r < 80) dx = 0;
    else if (r < 90) dx = $urandom_range(1, 255);
    else dx = 31'h7FFF_FFFF;
    r = $urandom_range(0, 99);
    if (r < 60) tol = 1;
    else if (r < 75) tol = 0;
    else if (r < 90) tol = $urandom_range(0, 1 << 23);
    else tol = 31'h7FFF_FFFF;
    if (noisy) span = $urandom_range(0, 3);
    else if (dx < 256) span = $urandom_range(0, 8);
    else span = $urandom_range(0, dx / 4);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      t1 = 31'h7FFF_FFFF;
      t0 = t1 - span;
    end else if (r < 16) begin
      t0 = 0;
      t1 = span;
    end else if (r < 26) begin
      // End at or before start: the run takes no step.
      t0 = $urandom_range(0, 1 << 30);
      t1 = t0 - $urandom_range(0, t0);
    end else begin
      t0 = $urandom_range(0, 31'h7FFF_FFFF - span);
      t1 = t0 + span;
    end
    drain();
    write_reg(CFG_CELL_COUNT, n_set);
    write_reg(CFG_CELL_WIDTH, dx);
    write_reg(CFG_START_TIME, t0);
    write_reg(CFG_END_TIME, t1);
    write_reg(CFG_DRY_TOL, tol);
    for (i = 0; i < n_eff; i++) begin
      if (noisy && $urandom_range(0, 1) == 1) send_word(OP_WRITE, i, $urandom, $urandom);
      else send_word(OP_WRITE, i, calm_height(), calm_flow());
    end
    read_some(2);
    send_word(OP_RUN, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) < 3) send_word(OP_RUN, $urandom, $urandom, $urandom);
    read_some(3);
  endtask

  // Every cell in use: the cell count register is set beyond the store and
  // clamps to the full size. The span fits in a single step.
  task automatic full_store_group();
    int i;
    drain();
    write_reg(CFG_CELL_COUNT, 11'd2047);
    write_reg(CFG_CELL_WIDTH, 1 << 24);
    write_reg(CFG_START_TIME, 0);
    write_reg(CFG_END_TIME, 1 << 19);
    write_reg(CFG_DRY_TOL, 1);
    for (i = 0; i < 1024; i++)
      send_word(OP_WRITE, i, $urandom_range(1 << 25, 1 << 22), calm_flow());
    send_word(OP_RUN, 0, 0, 0);
    read_some(5);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_WRITE;
    in_cell_index = '0;
    in_height_in = '0;
    in_discharge_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CELL_COUNT;
    cfg_data = '0;
    idle_tx = 1'b0;
    idle_rx = 1'b0;
    hold_long = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two cells, extreme values in unused cells, the unused
    // operation, then a short run.
    write_reg(CFG_CELL_COUNT, 2);
    write_reg(CFG_CELL_WIDTH, 1 << 24);
    write_reg(CFG_START_TIME, 0);
    write_reg(CFG_END_TIME, 1 << 22);
    write_reg(CFG_DRY_TOL, 1);
    send_word(OP_WRITE, 0, 1 << 24, 1 << 23);
    send_word(OP_WRITE, 1, 1 << 23, -(1 << 22));
    send_word(OP_WRITE, 1023, Q_MAX, Q_MIN);
    send_word(OP_WRITE, 512, Q_MIN, Q_MAX);
    send_word(OP_WRITE, 2, 0, 0);
    send_word(OP_READ, 1023, 0, 0);
    send_word(OP_READ, 512, 0, 0);
    send_word(2'd3, 1023, Q_MAX, Q_MIN);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_READ, 1, 0, 0);
    // Zero tolerance with a cell of zero height: that cell stays dry.
    drain();
    write_reg(CFG_DRY_TOL, 0);
    write_reg(CFG_CELL_COUNT, 3);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_READ, 2, 0, 0);
    // Start after end, then both at the top of the range: no step is taken.
    drain();
    write_reg(CFG_START_TIME, 5);
    write_reg(CFG_END_TIME, 0);
    send_word(OP_RUN, 0, 0, 0);
    drain();
    write_reg(CFG_START_TIME, 31'h7FFF_FFFF);
    write_reg(CFG_END_TIME, 31'h7FFF_FFFF);
    send_word(OP_RUN, 0, 0, 0);
    // Cell count below the minimum and a zero cell width, which forces
    // steps of a single least significant bit.
    drain();
    write_reg(CFG_CELL_COUNT, 0);
    write_reg(CFG_CELL_WIDTH, 0);
    write_reg(CFG_START_TIME, 0);
    write_reg(CFG_END_TIME, 3);
    write_reg(CFG_DRY_TOL, 1);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_READ, 1, 0, 0);

    // Random groups, each with its own idling mood.
    while (words_sent < WORD_TARGET) begin
      idle_tx = ($urandom_range(0, 3) != 0);
      idle_rx = ($urandom_range(0, 3) != 0);
      if (!big_done && words_sent > 300) begin
        full_store_group();
        big_done = 1'b1;
      end else if (!hold_done && words_sent > 150) begin
        idle_tx = 1'b0;
        hold_long = 1'b1;
        stream_group(40);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 40) begin
        stream_group($urandom_range(10, 30));
      end else begin
        solver_group($urandom_range(0, 99) < 20);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d command words (%0d solver runs); %0d result words checked.",
             words_sent, runs_seen, words_checked);
    $display("Covered cell counts from the clamped minimum to the full store of 1024.");
    if (pending != 0)
      $display("%0d expected result words never arrived.", pending);
    if (errors == 0 && pending == 0) begin
      $display("** shallow_water_lax_friedrichs_1d: PASSED **");
    end else begin
      $display("** shallow_water_lax_friedrichs_1d: FAILED **");
    end
    $finish;
  end

endmodule
